// ===== src/cpio_pkg.sv =====
package cpio_pkg;

    localparam logic [31:0] HDR_LEN     = 32'd110;
    localparam logic [31:0] MAGIC_LEN   = 32'd6;
    localparam logic [31:0] FSIZE_AT    = 32'd54;
    localparam logic [31:0] NSIZE_AT    = 32'd94;
    localparam logic [31:0] HEX_LEN     = 32'd8;
    localparam logic [31:0] TRAILER_LEN = 32'd11;

    localparam logic [2:0] EV_NAME_BYTE   = 3'd0;
    localparam logic [2:0] EV_ENTRY_SIZES = 3'd1;
    localparam logic [2:0] EV_DATA_BYTE   = 3'd2;
    localparam logic [2:0] EV_ARCHIVE_END = 3'd3;
    localparam logic [2:0] EV_BAD_MAGIC   = 3'd4;

    // expected "070701"
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "0";
            3'd1:    c = "7";
            3'd2:    c = "0";
            3'd3:    c = "7";
            3'd4:    c = "0";
            3'd5:    c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "TRAILER!!!" followed by nul
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // upper-case hex only, anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
        end
        return v;
    endfunction

endpackage

// ===== src/cpio_newc_archive_walker.sv =====
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_archive_byte, s_restart
// m_        out        m_valid / m_ready    m_event_res, m_byte_value, m_name_size,
//                                           m_file_size, m_data_last
// cfg_      in         cfg_valid / cfg_ready cfg_emit_data
//
// one archive byte per cycle: the byte is parsed in the cycle it is taken and
// its event (if any) appears in the output register on the next cycle.
// s_ready only drops while a held event is stalled by m_ready low.
// synchronous active-low reset returns the walker to the start of a header
// with emit_data set; cfg_ready is always high.
module cpio_newc_archive_walker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_archive_byte,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_byte_value,
    output logic [31:0] m_name_size,
    output logic [31:0] m_file_size,
    output logic        m_data_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_emit_data
);
    import cpio_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_NAME, PH_NAME_TAIL, PH_NAME_PAD,
        PH_DATA, PH_DATA_PAD, PH_ENDED, PH_STOPPED
    } phase_t;

    phase_t      phase_reg, phase_next, ph_cur;
    logic [31:0] pos_reg, pos_next, pos_cur;
    logic [31:0] nl_reg, nl_next, nl_cur;
    logic [31:0] dl_reg, dl_next, dl_cur;
    logic        magic_ok_reg, magic_ok_next, mok_cur;
    logic        trailer_reg, trailer_next, trl_cur;
    logic        emit_data_reg;

    logic        m_valid_reg;
    logic [2:0]  m_event_reg;
    logic [7:0]  m_byte_reg;
    logic [31:0] m_ns_reg;
    logic [31:0] m_fs_reg;
    logic        m_last_reg;

    logic        accept;
    logic [7:0]  b;
    logic        res_valid;
    logic [2:0]  res_event;
    logic [7:0]  res_byte;
    logic [31:0] res_ns;
    logic [31:0] res_fs;
    logic        res_last;
    logic        go_after_name, go_after_name_pad, go_after_data, go_start;
    logic        end_region;
    logic [1:0]  name_pad, data_pad;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign b         = s_archive_byte;

    always_comb begin
        // restart wipes the walk before this byte is looked at
        ph_cur  = s_restart ? PH_HEADER : phase_reg;
        pos_cur = s_restart ? 32'd0 : pos_reg;
        nl_cur  = s_restart ? 32'd0 : nl_reg;
        dl_cur  = s_restart ? 32'd0 : dl_reg;
        mok_cur = s_restart ? 1'b1 : magic_ok_reg;
        trl_cur = s_restart ? 1'b1 : trailer_reg;

        phase_next    = ph_cur;
        pos_next      = pos_cur;
        nl_next       = nl_cur;
        dl_next       = dl_cur;
        magic_ok_next = mok_cur;
        trailer_next  = trl_cur;

        res_valid = 1'b0;
        res_event = EV_NAME_BYTE;
        res_byte  = 8'd0;
        res_ns    = 32'd0;
        res_fs    = 32'd0;
        res_last  = 1'b0;

        go_after_name     = 1'b0;
        go_after_name_pad = 1'b0;
        go_after_data     = 1'b0;
        go_start          = 1'b0;
        end_region        = (pos_cur == nl_cur - 32'd1);

        unique case (ph_cur)
            PH_HEADER: begin
                if (pos_cur < MAGIC_LEN && b != magic_char(pos_cur[2:0])) begin
                    magic_ok_next = 1'b0;
                end
                if (pos_cur >= FSIZE_AT && pos_cur < FSIZE_AT + HEX_LEN) begin
                    dl_next = {dl_cur[27:0], hex_value(b)};
                end
                if (pos_cur >= NSIZE_AT && pos_cur < NSIZE_AT + HEX_LEN) begin
                    nl_next = {nl_cur[27:0], hex_value(b)};
                end
                pos_next = pos_cur + 32'd1;
                if (pos_cur == MAGIC_LEN - 32'd1 && !magic_ok_next) begin
                    res_valid  = 1'b1;
                    res_event  = EV_BAD_MAGIC;
                    phase_next = PH_STOPPED;
                end else if (pos_cur == HDR_LEN - 32'd1) begin
                    if (nl_next == 32'd0) begin
                        res_valid     = 1'b1;
                        res_event     = EV_ENTRY_SIZES;
                        res_ns        = nl_next;
                        res_fs        = dl_next;
                        go_after_name = 1'b1;
                    end else begin
                        phase_next = PH_NAME;
                        pos_next   = 32'd0;
                    end
                end
            end
            PH_NAME: begin
                if (pos_cur < TRAILER_LEN && b != trailer_char(pos_cur[3:0])) begin
                    trailer_next = 1'b0;
                end
                res_valid = 1'b1;
                if (b == 8'd0 || end_region) begin
                    res_ns = nl_cur;
                    res_fs = dl_cur;
                    if (trailer_next && pos_cur == TRAILER_LEN - 32'd1) begin
                        res_event  = EV_ARCHIVE_END;
                        phase_next = PH_ENDED;
                    end else begin
                        res_event = EV_ENTRY_SIZES;
                        if (end_region) begin
                            go_after_name = 1'b1;
                        end else begin
                            phase_next = PH_NAME_TAIL;
                            pos_next   = pos_cur + 32'd1;
                        end
                    end
                end else begin
                    res_event = EV_NAME_BYTE;
                    res_byte  = b;
                    pos_next  = pos_cur + 32'd1;
                end
            end
            PH_NAME_TAIL: begin
                if (pos_cur >= nl_cur - 32'd1) begin
                    go_after_name = 1'b1;
                end else begin
                    pos_next = pos_cur + 32'd1;
                end
            end
            PH_NAME_PAD: begin
                if ({1'b0, pos_cur} + 33'd1 >= {31'd0, 2'(2'd2 - nl_cur[1:0])}) begin
                    go_after_name_pad = 1'b1;
                end else begin
                    pos_next = pos_cur + 32'd1;
                end
            end
            PH_DATA: begin
                if (emit_data_reg) begin
                    res_valid = 1'b1;
                    res_event = EV_DATA_BYTE;
                    res_byte  = b;
                    res_last  = (pos_cur >= dl_cur - 32'd1);
                end
                if (pos_cur >= dl_cur - 32'd1) begin
                    go_after_data = 1'b1;
                end else begin
                    pos_next = pos_cur + 32'd1;
                end
            end
            PH_DATA_PAD: begin
                if ({1'b0, pos_cur} + 33'd1 >= {31'd0, 2'(2'd0 - dl_cur[1:0])}) begin
                    go_start = 1'b1;
                end else begin
                    pos_next = pos_cur + 32'd1;
                end
            end
            PH_ENDED, PH_STOPPED: begin
            end
        endcase

        // header + name is 110 + namesize bytes, padded to a multiple of 4
        name_pad = 2'd2 - nl_next[1:0];
        data_pad = 2'd0 - dl_next[1:0];
        if (go_after_name) begin
            if (name_pad != 2'd0) begin
                phase_next = PH_NAME_PAD;
                pos_next   = 32'd0;
            end else begin
                go_after_name_pad = 1'b1;
            end
        end
        if (go_after_name_pad) begin
            if (dl_next != 32'd0) begin
                phase_next = PH_DATA;
                pos_next   = 32'd0;
            end else begin
                go_after_data = 1'b1;
            end
        end
        if (go_after_data) begin
            if (data_pad != 2'd0) begin
                phase_next = PH_DATA_PAD;
                pos_next   = 32'd0;
            end else begin
                go_start = 1'b1;
            end
        end
        if (go_start) begin
            phase_next    = PH_HEADER;
            pos_next      = 32'd0;
            nl_next       = 32'd0;
            dl_next       = 32'd0;
            magic_ok_next = 1'b1;
            trailer_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 32'd0;
            nl_reg        <= 32'd0;
            dl_reg        <= 32'd0;
            magic_ok_reg  <= 1'b1;
            trailer_reg   <= 1'b1;
            emit_data_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                emit_data_reg <= cfg_emit_data;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                nl_reg       <= nl_next;
                dl_reg       <= dl_next;
                magic_ok_reg <= magic_ok_next;
                trailer_reg  <= trailer_next;
            end
            if (s_ready) begin
                m_valid_reg <= accept && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_event_reg <= res_event;
            m_byte_reg  <= res_byte;
            m_ns_reg    <= res_ns;
            m_fs_reg    <= res_fs;
            m_last_reg  <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_res  = m_event_reg;
    assign m_byte_value = m_byte_reg;
    assign m_name_size  = m_ns_reg;
    assign m_file_size  = m_fs_reg;
    assign m_data_last  = m_last_reg;

`ifndef SYNTHESIS
    // a stalled event must block the next byte
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while an event is stalled");

    // a stopped walk stays stopped until a restart transaction
    a_stopped_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STOPPED && !(s_valid && s_ready && s_restart))
        |=> phase_reg == PH_STOPPED)
        else $error("walk left stopped state without restart");

    a_header_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (pos_reg < HDR_LEN))
        else $error("header position past header length");

    a_last_only_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_last) |-> (m_event_res == EV_DATA_BYTE))
        else $error("data_last on a non-data event");
`endif

endmodule
